// ===== rtl/eeb_pkg.sv =====
// Package for the I2C EEPROM byte access block with read voting.
// Holds the sequencer state type, bus phase kinds and the per-tick step functions.
// No dependencies.
package eeb_pkg;

  typedef enum logic [3:0] {
    K_START, K_SEND_DW, K_SEND_DR, K_SEND_A, K_SEND_D,
    K_ACK, K_RECV, K_NOACK, K_STOP, K_GAP
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DEVICE   = 2'd0,
    CFG_PHASE    = 2'd1,
    CFG_GAP      = 2'd2,
    CFG_TRIES    = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [7:0] NACK_VALUE = 8'h55;
  localparam logic [3:0] READ_STOP_PHASE = 4'd11;
  localparam logic [3:0] WRITE_STOP_PHASE = 4'd8;
  localparam logic [6:0] DEVICE_RST = 7'd80;
  localparam logic [9:0] PHASE_RST = 10'd4;
  localparam logic [15:0] GAP_RST = 16'd1000;
  localparam logic [2:0] TRIES_RST = 3'd3;

  typedef struct packed {
    logic [6:0]  dev_sel;
    logic [9:0]  phase_ticks;
    logic [15:0] gap_ticks;
    logic [2:0]  tries;
  } cfg_t;

  typedef struct packed {
    logic [3:0]      ps;
    logic [15:0]     tc;
    logic [3:0]      bc;
    logic [7:0]      sb;
    logic [7:0]      ha;
    logic [7:0]      hd;
    logic [2:0][7:0] rs;
    logic [1:0]      rr;
    logic [2:0]      tcnt;
    logic            isw;
    logic [1:0]      sub;
    logic            rawwr;
    logic            ackf;
    logic            scl;
    logic            sda;
    logic            done;
    logic [7:0]      data;
    logic            err;
  } st_t;

  function automatic kind_t cur_kind(st_t s);
    kind_t k;
    k = K_GAP;
    if (s.rawwr) begin
      case (s.ps)
        4'd1: k = K_START;
        4'd2: k = K_SEND_DW;
        4'd3: k = K_ACK;
        4'd4: k = K_SEND_A;
        4'd5: k = K_ACK;
        4'd6: k = K_SEND_D;
        4'd7: k = K_ACK;
        4'd8: k = K_STOP;
        default: k = K_GAP;
      endcase
    end else begin
      case (s.ps)
        4'd1: k = K_START;
        4'd2: k = K_SEND_DW;
        4'd3: k = K_ACK;
        4'd4: k = K_SEND_A;
        4'd5: k = K_ACK;
        4'd6: k = K_START;
        4'd7: k = K_SEND_DR;
        4'd8: k = K_ACK;
        4'd9: k = K_RECV;
        4'd10: k = K_NOACK;
        4'd11: k = K_STOP;
        default: k = K_GAP;
      endcase
    end
    return k;
  endfunction

  function automatic st_t apply_lines(st_t s, cfg_t c);
    st_t r;
    kind_t k;
    logic [7:0] v;
    r = s;
    k = cur_kind(s);
    r.tc = (c.phase_ticks == '0) ? 16'd1 : {6'd0, c.phase_ticks};
    case (k)
      K_SEND_DW: v = {c.dev_sel, 1'b0};
      K_SEND_DR: v = {c.dev_sel, 1'b1};
      K_SEND_A:  v = s.ha;
      default:   v = s.hd;
    endcase
    case (k)
      K_START: begin
        case (s.sub)
          2'd0: r.sda = 1'b1;
          2'd1: r.scl = 1'b1;
          2'd2: r.sda = 1'b0;
          default: r.scl = 1'b0;
        endcase
      end
      K_SEND_DW, K_SEND_DR, K_SEND_A, K_SEND_D: begin
        if (s.bc < 4'd8) begin
          if (s.sub == 2'd0) r.sda = v[3'd7 - s.bc[2:0]];
          else if (s.sub == 2'd1) r.scl = 1'b1;
          else r.scl = 1'b0;
        end
      end
      K_ACK: begin
        if (s.sub == 2'd0) begin
          r.sda = 1'b1;
          r.scl = 1'b1;
        end else r.scl = 1'b0;
      end
      K_RECV: begin
        if (s.sub == 2'd0) begin
          r.sda = 1'b1;
          r.scl = 1'b0;
        end else r.scl = (s.sub == 2'd1);
      end
      K_NOACK: begin
        if (s.sub == 2'd0) begin
          r.sda = 1'b1;
          r.scl = 1'b0;
        end else if (s.sub == 2'd2) r.scl = 1'b1;
      end
      K_STOP: begin
        if (s.sub == 2'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b0;
        end else if (s.sub == 2'd1) r.scl = 1'b1;
      end
      default: begin
        r.scl = 1'b1;
        r.sda = 1'b1;
        r.tc = c.gap_ticks;
      end
    endcase
    return r;
  endfunction

  function automatic st_t enter_phase(st_t s, cfg_t c, logic [3:0] ps);
    st_t r;
    r = s;
    r.ps = ps;
    r.sub = 2'd0;
    r.bc = 4'd0;
    r.ackf = 1'b0;
    return apply_lines(r, c);
  endfunction

  function automatic st_t start_raw(st_t s, cfg_t c, logic wr);
    st_t r;
    r = s;
    r.rawwr = wr;
    return enter_phase(r, c, 4'd1);
  endfunction

  function automatic st_t finish_cmd(st_t s, logic [7:0] val, logic e);
    st_t r;
    r = s;
    r.ps = 4'd0;
    r.tc = 16'd0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    r.done = 1'b1;
    r.data = val;
    r.err = e;
    return r;
  endfunction

  function automatic st_t after_vote(st_t s, cfg_t c, logic [7:0] v, logic verr);
    st_t r;
    logic [2:0] tries;
    r = s;
    tries = (c.tries == '0) ? 3'd1 : c.tries;
    if (!s.isw) r = finish_cmd(s, v, verr);
    else if (v == s.hd) r = finish_cmd(s, 8'd0, verr);
    else begin
      r.tcnt = s.tcnt + 3'd1;
      if (r.tcnt >= tries) r = finish_cmd(r, 8'd0, 1'b1);
      else r = start_raw(r, c, 1'b1);
    end
    return r;
  endfunction

  function automatic st_t raw_done(st_t s, cfg_t c);
    st_t r;
    r = s;
    if (s.rawwr) begin
      r.rr = 2'd0;
      r = start_raw(r, c, 1'b0);
    end else begin
      if (s.rr != 2'd3) r.rs[s.rr] = s.sb;
      r.rr = s.rr + 2'd1;
      if (r.rr < 2'd2) r = start_raw(r, c, 1'b0);
      else if (r.rr == 2'd2) begin
        if (r.rs[0] == r.rs[1]) r = after_vote(r, c, r.rs[0], 1'b0);
        else r = start_raw(r, c, 1'b0);
      end else if (r.rs[0] == r.rs[2]) r = after_vote(r, c, r.rs[0], 1'b0);
      else if (r.rs[1] == r.rs[2]) r = after_vote(r, c, r.rs[1], 1'b0);
      else r = after_vote(r, c, NACK_VALUE, 1'b1);
    end
    return r;
  endfunction

  function automatic st_t end_segment(st_t s, cfg_t c, logic sda);
    st_t r;
    r = s;
    case (cur_kind(s))
      K_START: begin
        if (s.sub < 2'd3) begin
          r.sub = s.sub + 2'd1;
          r = apply_lines(r, c);
        end else r = enter_phase(r, c, s.ps + 4'd1);
      end
      K_SEND_DW, K_SEND_DR, K_SEND_A, K_SEND_D: begin
        if (s.bc >= 4'd8) r = enter_phase(r, c, s.ps + 4'd1);
        else begin
          if (s.sub < 2'd2) r.sub = s.sub + 2'd1;
          else begin
            r.sub = 2'd0;
            r.bc = s.bc + 4'd1;
          end
          r = apply_lines(r, c);
        end
      end
      K_ACK: begin
        if (s.sub == 2'd0) begin
          r.ackf = sda;
          r.sub = 2'd1;
          r = apply_lines(r, c);
        end else if (s.ackf) begin
          r.sb = NACK_VALUE;
          r = enter_phase(r, c, s.rawwr ? WRITE_STOP_PHASE : READ_STOP_PHASE);
        end else r = enter_phase(r, c, s.ps + 4'd1);
      end
      K_RECV: begin
        if (s.sub == 2'd1) begin
          r.sb = {s.sb[6:0], sda};
          r.sub = 2'd2;
          r = apply_lines(r, c);
        end else if (s.sub == 2'd2) begin
          if (s.bc >= 4'd7) r = enter_phase(r, c, s.ps + 4'd1);
          else begin
            r.bc = s.bc + 4'd1;
            r.sub = 2'd1;
            r = apply_lines(r, c);
          end
        end else begin
          r.sub = 2'd1;
          r = apply_lines(r, c);
        end
      end
      K_NOACK, K_STOP: begin
        if (s.sub < 2'd2) begin
          r.sub = s.sub + 2'd1;
          r = apply_lines(r, c);
        end else r = enter_phase(r, c, s.ps + 4'd1);
      end
      default: r = raw_done(s, c);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/eeb_if.sv =====
// Channel interfaces for the I2C EEPROM byte access block.
// Depends on eeb_pkg for the configuration index width.
interface eeb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic       operation;
  logic [7:0] mem_address;
  logic [7:0] write_data;
  logic       sda_in;
  modport source (output valid, cmd_valid, operation, mem_address, write_data, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, operation, mem_address, write_data, sda_in,
                output ready);
endinterface

interface eeb_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       error;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, error,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_data, error,
                output ready);
endinterface

interface eeb_cfg_if import eeb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/eeb_core.sv =====
// Bus sequencer state and the per-tick step logic.
// Depends on eeb_pkg for the state type and step functions.
module eeb_core import eeb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  input  logic       operation,
  input  logic [7:0] mem_address,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  output st_t        res
);

  st_t st;
  st_t st_next;

  always_comb begin
    st_next = st;
    st_next.done = 1'b0;
    st_next.err = 1'b0;
    st_next.data = 8'd0;
    if (st.ps == 4'd0) begin
      if (cmd_valid) begin
        st_next.isw = operation;
        st_next.ha = mem_address;
        st_next.hd = write_data;
        st_next.rr = 2'd0;
        st_next.tcnt = 3'd0;
        st_next = start_raw(st_next, cfg, operation);
      end
    end else begin
      if (st_next.tc != '0) st_next.tc = st_next.tc - 16'd1;
      for (int i = 0; i < 2; i++) begin
        if (st_next.ps != 4'd0 && st_next.tc == '0) begin
          st_next = end_segment(st_next, cfg, sda_in);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{scl: 1'b1, sda: 1'b1, default: '0};
    end else if (en) begin
      st <= st_next;
    end
  end

  assign res = st_next;

endmodule

// ===== rtl/i2c_eeprom_byte_access_voting_top.sv =====
// Top level of the I2C EEPROM byte access block with read voting.
// Depends on eeb_pkg, the channel interfaces and eeb_core.
//
//   channel  direction  word
//   in_ch    sink       one bus tick: command fields and sampled SDA
//   out_ch   source     line drives and status for that tick
//   cfg_ch   sink       register index and write data
//
// A tick can be accepted in every cycle while the result is not stalled.
// The step logic runs between the sequencer state and the result register.
// Reset is synchronous and restores the register defaults and the idle state.
// A stalled result is held and the next tick waits until it is taken.
module i2c_eeprom_byte_access_voting_top import eeb_pkg::*; (
  input logic     clk,
  input logic     rst,
  eeb_in_if.sink   in_ch,
  eeb_out_if.source out_ch,
  eeb_cfg_if.sink  cfg_ch
);

  cfg_t cfg;
  st_t  res;
  logic acc;
  logic out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_sel <= DEVICE_RST;
      cfg.phase_ticks <= PHASE_RST;
      cfg.gap_ticks <= GAP_RST;
      cfg.tries <= TRIES_RST;
    end else if (cfg_ch.valid && cfg_ch.index < CFG_IDX_W'(4)) begin
      case (cfg_reg_t'(cfg_ch.index[1:0]))
        CFG_DEVICE:   cfg.dev_sel <= cfg_ch.data[6:0];
        CFG_PHASE:    cfg.phase_ticks <= cfg_ch.data[9:0];
        CFG_GAP:      cfg.gap_ticks <= cfg_ch.data;
        CFG_TRIES:    cfg.tries <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  eeb_core u_core (
    .clk(clk), .rst(rst), .en(acc), .cfg(cfg),
    .cmd_valid(in_ch.cmd_valid), .operation(in_ch.operation),
    .mem_address(in_ch.mem_address), .write_data(in_ch.write_data),
    .sda_in(in_ch.sda_in), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (acc) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_ch.scl_out <= res.scl;
      out_ch.sda_out <= res.sda;
      out_ch.busy_res <= res.ps != 4'd0;
      out_ch.done_res <= res.done;
      out_ch.read_data <= res.data;
      out_ch.error <= res.err;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/eeb_chk.sv =====
// Port checker for the I2C EEPROM byte access block.
// Depends only on the top level's ports; bound to the top level below.
module eeb_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_out,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_data,
  input logic       error
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res) else $error("done while busy");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> done_res) else $error("error outside done");

  a_data_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != 8'd0 |-> done_res) else $error("data outside done");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scl_out)) else $error("stall lost");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("valid after reset");

endmodule

bind i2c_eeprom_byte_access_voting_top eeb_chk u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .scl_out(out_ch.scl_out), .busy_res(out_ch.busy_res), .done_res(out_ch.done_res),
  .read_data(out_ch.read_data), .error(out_ch.error)
);
